// ===== rtl/life_automaton_trail_fader_top_macros.svh =====
// Assertion helpers used by the top-level RTL
`ifndef LIFE_AUTOMATON_TRAIL_FADER_TOP_MACROS_SVH
`define LIFE_AUTOMATON_TRAIL_FADER_TOP_MACROS_SVH

// same-cycle implication
`define LFD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lfd: check failed");

// next-cycle implication
`define LFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lfd: check failed");

`endif

// ===== rtl/lfd_pkg.sv =====
package lfd_pkg;

  localparam int unsigned LedW    = 11;
  localparam int unsigned DrawW   = 14;
  localparam int unsigned BirthW  = 11;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 14;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BIRTH_BRI = 3'd0,
    CFG_BIRTH_SAT = 3'd1,
    CFG_TRAIL     = 3'd2,
    CFG_SPAWN     = 3'd3,
    CFG_SEED      = 3'd4,
    CFG_HUE_STEP  = 3'd5
  } lfd_cfg_e;

  // life verdict for the cell being accepted
  typedef struct packed {
    logic prev;
    logic birth;
  } lfd_life_t;

  // control signals for the current cell handed to the life store
  typedef struct packed {
    logic accept;
    logic kind;
    logic seed_alive;
    logic spawn;
    logic plane;
    logic col_end;
  } lfd_ctl_t;

endpackage

// ===== rtl/life_automaton_trail_fader_top.sv =====
// Game of Life engine with a fading colour trail, one cell per transaction.
// Input channel: in_valid_i / in_stall_o with kind_i and draw_i. Cells are
// visited column by column, row fastest; every transaction advances the scan.
// Seed transactions give no result; generation transactions give one result
// on out_valid_o / out_stall_i: the LED index and the colour held before the
// update, plus pass_end_o and needs_reseed_o on the last cell.
// Throughput is one cell per cycle while the receiver does not stall. A result
// passes through the read stage for the colour memory and then the output
// register. Life state lives in a column memory behind a three-column
// window, so all eight neighbours are read in the same cycle.
// When the receiver stalls, one result waits in the output register and one
// more cell waits in the read stage; after that in_stall_o rises.
// Configuration writes through cfg_we_i / cfg_idx_i / cfg_data_i take effect
// at once and must be made by the user while the block is idle (not enforced).
// Reset clears all cells to dead, colours to hue 0, saturation 255,
// brightness 0, the hue to 160 and the scan to the first cell. No clearing
// pass is needed, so transactions are taken right after reset.
module life_automaton_trail_fader_top #(
  parameter int unsigned GRID_WIDTH  = 30,
  parameter int unsigned GRID_HEIGHT = 37
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lfd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lfd_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        kind_i,
  input  logic [lfd_pkg::DrawW-1:0]   draw_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [lfd_pkg::LedW-1:0]    led_index_o,
  output logic [7:0]                  pixel_hue_o,
  output logic [7:0]                  pixel_saturation_o,
  output logic [7:0]                  pixel_brightness_o,
  output logic                        pass_end_o,
  output logic                        needs_reseed_o
);
  import lfd_pkg::*;

  localparam int unsigned XW = $clog2(GRID_WIDTH);
  localparam int unsigned YW = $clog2(GRID_HEIGHT);
  localparam int unsigned PW = XW + YW + 1;
  localparam int unsigned CellCount = GRID_WIDTH * GRID_HEIGHT;
  localparam int unsigned IW = $clog2(CellCount);

  logic [7:0] bri_q, sat_q, trail_q, seed_q, step_q, hue_q;
  logic [DrawW-1:0] spawn_q;
  logic [XW-1:0] x_q;
  logic [YW-1:0] y_q;
  logic plane_q, done_q;
  logic [BirthW-1:0] birth_cnt_q, birth_cnt_d;

  logic in_acc, last, col_end, few;
  logic [PW-1:0] base, idx_full, led_full;
  logic [IW-1:0] idx;
  lfd_ctl_t ctl;
  lfd_life_t life;

  logic s1_valid_q, s1_move, s1_gen_q, s1_seed_alive_q, s1_prev_q, s1_birth_q;
  logic s1_spawn_q, s1_end_q, s1_few_q, s1_cval_q;
  logic [7:0] s1_hue_q;
  logic [LedW-1:0] s1_led_q;
  logic [IW-1:0] s1_idx_q;

  logic [23:0] colour_mem [CellCount];
  logic [23:0] rd_q, old_col, new_col;
  logic [7:0] fade, v_fade;

  logic out_valid_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign col_end = (y_q == YW'(GRID_HEIGHT - 1));
  assign last    = col_end && (x_q == XW'(GRID_WIDTH - 1));

  assign s1_move    = s1_valid_q && (!s1_gen_q || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_move;

  assign base     = PW'(x_q) * PW'(GRID_HEIGHT);
  assign idx_full = base + PW'(y_q);
  assign idx      = IW'(idx_full);
  assign led_full = x_q[0] ? idx_full : base + PW'(GRID_HEIGHT) - PW'(y_q) - PW'(1);

  assign ctl.accept     = in_acc;
  assign ctl.kind       = kind_i;
  assign ctl.seed_alive = draw_i < DrawW'(seed_q);
  assign ctl.spawn      = draw_i < spawn_q;
  assign ctl.plane      = plane_q;
  assign ctl.col_end    = col_end;

  lfd_life #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT)
  ) u_life (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (ctl),
    .col_i (x_q),
    .row_i (y_q),
    .life_o(life)
  );

  always_comb begin
    birth_cnt_d = birth_cnt_q;
    if (in_acc && kind_i && life.birth && birth_cnt_q != '1) begin
      birth_cnt_d = birth_cnt_q + BirthW'(1);
    end
  end
  assign few = birth_cnt_d < BirthW'(3);

  // configuration, scan and pass state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bri_q       <= 8'd255;
      sat_q       <= 8'd255;
      trail_q     <= 8'd230;
      spawn_q     <= DrawW'(10);
      seed_q      <= 8'd64;
      step_q      <= 8'd1;
      hue_q       <= 8'd160;
      x_q         <= '0;
      y_q         <= '0;
      plane_q     <= 1'b0;
      done_q      <= 1'b0;
      birth_cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (lfd_cfg_e'(cfg_idx_i))
          CFG_BIRTH_BRI: bri_q   <= cfg_data_i[7:0];
          CFG_BIRTH_SAT: sat_q   <= cfg_data_i[7:0];
          CFG_TRAIL:     trail_q <= cfg_data_i[7:0];
          CFG_SPAWN:     spawn_q <= cfg_data_i;
          CFG_SEED:      seed_q  <= cfg_data_i[7:0];
          CFG_HUE_STEP:  step_q  <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        if (last) begin
          x_q         <= '0;
          y_q         <= '0;
          done_q      <= 1'b1;
          birth_cnt_q <= '0;
          if (kind_i) begin
            hue_q   <= hue_q + step_q;
            plane_q <= !plane_q;
          end
        end else begin
          birth_cnt_q <= birth_cnt_d;
          if (col_end) begin
            y_q <= '0;
            x_q <= x_q + XW'(1);
          end else begin
            y_q <= y_q + YW'(1);
          end
        end
      end
    end
  end

  // read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_gen_q        <= kind_i;
      s1_seed_alive_q <= ctl.seed_alive;
      s1_prev_q       <= life.prev;
      s1_birth_q      <= life.birth;
      s1_spawn_q      <= ctl.spawn;
      s1_hue_q        <= hue_q;
      s1_led_q        <= LedW'(led_full);
      s1_end_q        <= last && kind_i;
      s1_few_q        <= last && kind_i && few;
      s1_cval_q       <= done_q;
      s1_idx_q        <= idx;
      rd_q            <= colour_mem[idx];
    end
    if (s1_move) begin
      colour_mem[s1_idx_q] <= new_col;
    end
  end

  // colour update; a cell not yet written in the first pass reads as reset
  assign old_col = s1_cval_q ? rd_q : {8'd0, 8'd255, 8'd0};
  assign fade    = 8'd255 - trail_q;
  assign v_fade  = (old_col[7:0] > fade) ? old_col[7:0] - fade : 8'd0;

  always_comb begin
    new_col = old_col;
    if (!s1_gen_q) begin
      new_col = {8'd0, old_col[15:8], s1_seed_alive_q ? bri_q : 8'd0};
    end else begin
      if (!s1_prev_q) begin
        new_col[7:0] = v_fade;
      end
      if (s1_birth_q) begin
        new_col = {s1_hue_q, sat_q, bri_q};
      end
      if (s1_spawn_q) begin
        new_col = {s1_hue_q, 8'd255, bri_q};
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move && s1_gen_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && s1_gen_q) begin
      led_index_o        <= s1_led_q;
      pixel_hue_o        <= old_col[23:16];
      pixel_saturation_o <= old_col[15:8];
      pixel_brightness_o <= old_col[7:0];
      pass_end_o         <= s1_end_q;
      needs_reseed_o     <= s1_few_q;
    end
  end

  assign out_valid_o = out_valid_q;

`include "life_automaton_trail_fader_top_macros.svh"

  `LFD_ASSERT_SAME(a_stall_needs_stage, in_stall_o, s1_valid_q)
  `LFD_ASSERT_SAME(a_reseed_at_end, out_valid_o && needs_reseed_o, pass_end_o)
  `LFD_ASSERT_NEXT(a_plane_swap, in_acc && last && kind_i, plane_q != $past(plane_q))

endmodule

// ===== rtl/lfd_life.sv =====
module lfd_life #(
  parameter int unsigned GRID_WIDTH  = 30,
  parameter int unsigned GRID_HEIGHT = 37,
  localparam int unsigned XW = $clog2(GRID_WIDTH),
  localparam int unsigned YW = $clog2(GRID_HEIGHT)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lfd_pkg::lfd_ctl_t ctl_i,
  input  logic [XW-1:0]     col_i,
  input  logic [YW-1:0]     row_i,
  output lfd_pkg::lfd_life_t life_o
);
  import lfd_pkg::*;

  typedef logic [1:0][GRID_HEIGHT-1:0] col_t;

  col_t col_mem [GRID_WIDTH];
  col_t l_q, c_q, r_q, c_next, rd_q;
  logic rd_vld_q;
  logic [GRID_WIDTH-1:0] vld_q;
  logic [XW:0] xp2;
  logic [XW-1:0] pf_addr;
  logic [YW-1:0] yu, yd;
  logic [3:0] cnt;
  logic [GRID_HEIGHT-1:0] lc, cc, rc;
  logic prev, birth, alive_nxt;

  // column two ahead, prefetched while the current column is scanned
  assign xp2 = {1'b0, col_i} + (XW+1)'(2);
  assign pf_addr = (xp2 >= (XW+1)'(GRID_WIDTH)) ? XW'(xp2 - (XW+1)'(GRID_WIDTH))
                                                : XW'(xp2);

  assign yu = (row_i == '0) ? YW'(GRID_HEIGHT - 1) : row_i - YW'(1);
  assign yd = (row_i == YW'(GRID_HEIGHT - 1)) ? '0 : row_i + YW'(1);

  assign lc = l_q[ctl_i.plane];
  assign cc = c_q[ctl_i.plane];
  assign rc = r_q[ctl_i.plane];

  assign cnt = 4'(lc[yu]) + 4'(lc[row_i]) + 4'(lc[yd]) + 4'(cc[yu]) + 4'(cc[yd])
             + 4'(rc[yu]) + 4'(rc[row_i]) + 4'(rc[yd]);

  assign prev      = cc[row_i];
  assign birth     = !prev && (cnt == 4'd3);
  assign alive_nxt = ctl_i.spawn || birth || (prev && (cnt == 4'd2 || cnt == 4'd3));

  assign life_o.prev  = prev;
  assign life_o.birth = birth;

  always_comb begin
    c_next = c_q;
    if (ctl_i.kind) begin
      c_next[!ctl_i.plane][row_i] = alive_nxt;
    end else begin
      c_next[0][row_i] = ctl_i.seed_alive;
      c_next[1][row_i] = ctl_i.seed_alive;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept && ctl_i.col_end) begin
      col_mem[col_i] <= c_next;
    end
    rd_q <= col_mem[pf_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_q      <= '0;
      c_q      <= '0;
      r_q      <= '0;
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[pf_addr];
      if (ctl_i.accept) begin
        if (ctl_i.col_end) begin
          // shift the window one column on, write back the finished one
          vld_q[col_i] <= 1'b1;
          l_q <= c_next;
          c_q <= r_q;
          r_q <= rd_vld_q ? rd_q : '0;
        end else begin
          c_q <= c_next;
        end
      end
    end
  end

endmodule

// ===== tb/life_automaton_trail_fader_top_tb.sv =====
module life_automaton_trail_fader_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lfd_pkg::*;

  localparam int unsigned GW = 30;
  localparam int unsigned GH = 37;
  localparam int unsigned CELLS = GW * GH;
  localparam int unsigned STALL_LIMIT = 20000;

  typedef struct packed {
    logic [LedW-1:0] led;
    logic [7:0]      hue;
    logic [7:0]      sat;
    logic [7:0]      bri;
    logic            pass_end;
    logic            reseed;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic kind_i = 1'b0;
  logic [DrawW-1:0] draw_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [LedW-1:0] led_index_o;
  logic [7:0] pixel_hue_o, pixel_saturation_o, pixel_brightness_o;
  logic pass_end_o, needs_reseed_o;

  always #2 clk_i = ~clk_i;

  life_automaton_trail_fader_top #(.GRID_WIDTH(GW), .GRID_HEIGHT(GH)) i_dut (.*);

  // predictor state
  logic [1:0]  life_mem [CELLS];
  logic [23:0] colour_mem [CELLS];
  logic        plane;
  logic [7:0]  hue_reg;
  int unsigned births;
  int unsigned scan_x, scan_y;
  logic [7:0]  c_bri, c_sat, c_trail, c_seed, c_step;
  logic [13:0] c_spawn;

  pixel_t pixels_due[$];
  int unsigned send_idle_pct = 0, stall_pct = 0;
  int unsigned quiet_cycles = 0;
  bit failed = 0;

  function automatic logic alive_at(int x, int y);
    int xi, yi;
    xi = (x + GW) % GW;
    yi = (y + GH) % GH;
    return life_mem[xi * GH + yi][plane];
  endfunction

  function automatic void predict_cell(logic kind, logic [13:0] draw);
    int unsigned idx, cnt, fade;
    logic prev, alive, last;
    logic [7:0] h, s, v;
    pixel_t px;
    idx = scan_x * GH + scan_y;
    {h, s, v} = colour_mem[idx];
    last = (scan_x == GW - 1) && (scan_y == GH - 1);
    if (!kind) begin
      alive = draw < c_seed;
      life_mem[idx] = alive ? 2'b11 : 2'b00;
      colour_mem[idx] = {8'd0, s, alive ? c_bri : 8'd0};
    end else begin
      px.led = (scan_x & 1) ? scan_x * GH + scan_y : (scan_x + 1) * GH - scan_y - 1;
      px.hue = h;
      px.sat = s;
      px.bri = v;
      px.pass_end = 1'b0;
      px.reseed = 1'b0;
      prev = life_mem[idx][plane];
      alive = prev;
      cnt = 0;
      for (int dx = -1; dx <= 1; dx++)
        for (int dy = -1; dy <= 1; dy++)
          if (dx != 0 || dy != 0) cnt += alive_at(scan_x + dx, scan_y + dy);
      if (v > 0 && !prev) begin
        fade = 255 - c_trail;
        v = (v > fade) ? v - fade : 8'd0;
      end
      if (cnt == 3 && !prev) begin
        alive = 1'b1;
        h = hue_reg;
        v = c_bri;
        s = c_sat;
        if (births < 2047) births++;
      end else if ((cnt < 2 || cnt > 3) && prev) begin
        alive = 1'b0;
      end
      if (draw < c_spawn) begin
        alive = 1'b1;
        v = c_bri;
        h = hue_reg;
        s = 8'd255;
      end
      colour_mem[idx] = {h, s, v};
      life_mem[idx][~plane] = alive;
      if (last) begin
        px.pass_end = 1'b1;
        px.reseed = births < 3;
        hue_reg = hue_reg + c_step;
        plane = ~plane;
      end
      pixels_due.push_back(px);
    end
    if (last) begin
      births = 0;
      scan_x = 0;
      scan_y = 0;
    end else if (scan_y == GH - 1) begin
      scan_y = 0;
      scan_x++;
    end else begin
      scan_y++;
    end
  endfunction

  // receiver side: random stall and result check
  always @(posedge clk_i) begin
    pixel_t exp_px;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pixels_due.size() == 0) begin
        $error("unexpected result led_index %0d", led_index_o);
        failed = 1;
      end else begin
        exp_px = pixels_due.pop_front();
        if (led_index_o !== exp_px.led) begin
          $error("led_index exp %0d got %0d", exp_px.led, led_index_o); failed = 1;
        end
        if (pixel_hue_o !== exp_px.hue) begin
          $error("pixel_hue exp %0d got %0d", exp_px.hue, pixel_hue_o); failed = 1;
        end
        if (pixel_saturation_o !== exp_px.sat) begin
          $error("pixel_saturation exp %0d got %0d", exp_px.sat, pixel_saturation_o);
          failed = 1;
        end
        if (pixel_brightness_o !== exp_px.bri) begin
          $error("pixel_brightness exp %0d got %0d", exp_px.bri, pixel_brightness_o);
          failed = 1;
        end
        if (pass_end_o !== exp_px.pass_end) begin
          $error("pass_end exp %0d got %0d", exp_px.pass_end, pass_end_o); failed = 1;
        end
        if (needs_reseed_o !== exp_px.reseed) begin
          $error("needs_reseed exp %0d got %0d", exp_px.reseed, needs_reseed_o);
          failed = 1;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // watchdog on cycles with no accepted transaction, result or config write while work is pending
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i
        || (!in_valid_i && pixels_due.size() == 0))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("life_automaton_trail_fader_top_tb: errors");
      $finish;
    end
  end

  // valid stays high after a transaction until the next one or an idle cycle
  task automatic send_cell(logic kind, logic [13:0] draw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    draw_i <= draw;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_cell(kind, draw);
  endtask

  task automatic write_reg(lfd_cfg_e idx, logic [13:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_BIRTH_BRI: c_bri = val[7:0];
      CFG_BIRTH_SAT: c_sat = val[7:0];
      CFG_TRAIL:     c_trail = val[7:0];
      CFG_SPAWN:     c_spawn = val;
      CFG_SEED:      c_seed = val[7:0];
      CFG_HUE_STEP:  c_step = val[7:0];
      default: ;
    endcase
  endtask

  // seed transactions give no result, so wait past the pipeline after the last result
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [7:0] bri, logic [7:0] sat, logic [7:0] trail,
                          logic [13:0] spawn, logic [7:0] seed, logic [7:0] step);
    drain();
    write_reg(CFG_BIRTH_BRI, bri);
    write_reg(CFG_BIRTH_SAT, sat);
    write_reg(CFG_TRAIL, trail);
    write_reg(CFG_SPAWN, spawn);
    write_reg(CFG_SEED, seed);
    write_reg(CFG_HUE_STEP, step);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_directed();
    // extremes of draw and both kinds, no idling
    send_cell(1'b1, 14'd0);
    send_cell(1'b1, 14'h3fff);
    send_cell(1'b0, 14'd0);
    send_cell(1'b0, 14'h3fff);
    send_cell(1'b0, 14'd63);
    send_cell(1'b0, 14'd64);
    send_cell(1'b1, 14'd9);
    send_cell(1'b1, 14'd10);
    send_cell(1'b1, 14'd9999);
    send_cell(1'b1, 14'h2aaa);
    send_cell(1'b0, 14'h1555);
    send_cell(1'b1, 14'd10000);
  endtask

  // seed a run of cells, then generate up to the end of the current pass
  task automatic test_seed_then_generate(int unsigned seeds);
    for (int unsigned c = 0; c < seeds; c++) send_cell(1'b0, 14'($urandom_range(254)));
    while (scan_x != 0 || scan_y != 0) send_cell(1'b1, 14'($urandom_range(9999)));
  endtask

  task automatic test_generate(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_cell(1'b1, 14'($urandom_range(9999)));
  endtask

  task automatic test_noise(int unsigned n);
    for (int i = 0; i < n; i++) send_cell(1'($urandom), 14'($urandom));
  endtask

  initial begin
    c_bri = 8'd255; c_sat = 8'd255; c_trail = 8'd230;
    c_spawn = 14'd10; c_seed = 8'd64; c_step = 8'd1;
    plane = 1'b0; hue_reg = 8'd160; births = 0; scan_x = 0; scan_y = 0;
    for (int i = 0; i < CELLS; i++) begin
      life_mem[i] = 2'b00;
      colour_mem[i] = {8'd0, 8'd255, 8'd0};
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    set_regs(8'd200, 8'd17, 8'd255, 14'd0, 8'd80, 8'd255);
    send_idle_pct = 50;
    test_seed_then_generate(400);
    set_regs(8'd0, 8'd0, 8'd0, 14'h3fff, 8'd0, 8'd0);
    send_idle_pct = 0; stall_pct = 50;
    test_noise(150);
    set_regs(8'd255, 8'd128, 8'd200, 14'd5, 8'd255, 8'd37);
    send_idle_pct = 35; stall_pct = 35;
    test_generate(250);
    set_regs(8'd180, 8'd90, 8'd240, 14'd3, 8'd90, 8'd3);
    send_idle_pct = 0; stall_pct = 0;
    test_noise(60);

    drain();
    if (!failed)
      $display("life_automaton_trail_fader_top_tb: clean");
    else
      $display("life_automaton_trail_fader_top_tb: errors");
    $finish;
  end
endmodule
